/* rtl/core/load_cell_change_detector_unit_assert.svh */
`ifndef LOAD_CELL_CHANGE_DETECTOR_UNIT_ASSERT_SVH
`define LOAD_CELL_CHANGE_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define LCCD_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("lccd assertion failed");

// next-cycle implication
`define LCCD_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("lccd assertion failed");

`endif

/* rtl/core/lccd_pkg.sv */
package lccd_pkg;

  localparam int WEIGHT_BITS_DEF = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int NOISE_W  = 16;
  localparam int THRESH_W = 20;
  localparam int BAND_W   = 20;
  localparam int WIN_W    = 16;
  localparam int SHIFT_W  = 3;
  localparam int TIME_W   = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOISE_FLOOR     = 3'd0,
    REG_ITEM_THRESHOLD  = 3'd1,
    REG_STABLE_BAND     = 3'd2,
    REG_WINDOW_MS       = 3'd3,
    REG_SMOOTHING_SHIFT = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  localparam logic [NOISE_W-1:0]  NOISE_FLOOR_RST     = 16'd80;
  localparam logic [THRESH_W-1:0] ITEM_THRESHOLD_RST  = 20'd800;
  localparam logic [BAND_W-1:0]   STABLE_BAND_RST     = 20'd240;
  localparam logic [WIN_W-1:0]    WINDOW_MS_RST       = 16'd800;
  localparam logic [SHIFT_W-1:0]  SMOOTHING_SHIFT_RST = 3'd2;

endpackage

/* rtl/core/load_cell_change_detector_unit.sv */
// Load-cell change detector. Takes one word per clock (cmd, signed sample in 1/16 g,
// ms timestamp) and returns exactly one result word per input word. An input word is
// captured in an input register, then the update logic (exponential smoother,
// noise clamp, window min/max, window judgment) writes the state and the output
// register; throughput is one word per cycle while the output side keeps taking
// results. A clear command zeroes all state and restarts the window at its
// timestamp. Configuration registers should be written only while idle.
`include "load_cell_change_detector_unit_assert.svh"

module load_cell_change_detector_unit
  import lccd_pkg::*;
#(
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic signed [WEIGHT_BITS-1:0] in_sample_weight,
  input  logic [TIME_W-1:0]             in_now_ms,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_changed,
  output logic                          out_added,
  output logic [WEIGHT_BITS-2:0]        out_new_weight,
  output logic signed [WEIGHT_BITS-1:0] out_weight_change
);

  localparam int W  = WEIGHT_BITS;
  localparam int CW = ((W > THRESH_W) ? W : THRESH_W) + 1;

  // config registers
  logic [NOISE_W-1:0]  noise_floor_r;
  logic [THRESH_W-1:0] item_threshold_r;
  logic [BAND_W-1:0]   stable_band_r;
  logic [WIN_W-1:0]    window_ms_r;
  logic [SHIFT_W-1:0]  smoothing_shift_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_floor_r     <= NOISE_FLOOR_RST;
      item_threshold_r  <= ITEM_THRESHOLD_RST;
      stable_band_r     <= STABLE_BAND_RST;
      window_ms_r       <= WINDOW_MS_RST;
      smoothing_shift_r <= SMOOTHING_SHIFT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NOISE_FLOOR:     noise_floor_r     <= cfg_data[NOISE_W-1:0];
        REG_ITEM_THRESHOLD:  item_threshold_r  <= cfg_data[THRESH_W-1:0];
        REG_STABLE_BAND:     stable_band_r     <= cfg_data[BAND_W-1:0];
        REG_WINDOW_MS:       window_ms_r       <= cfg_data[WIN_W-1:0];
        REG_SMOOTHING_SHIFT: smoothing_shift_r <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                  in_vld_r;
  logic                  cmd_r;
  logic signed [W-1:0]   sample_r;
  logic [TIME_W-1:0]     now_r;
  logic                  advance;

  assign advance  = in_vld_r && (!out_valid || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r    <= in_cmd;
      sample_r <= in_sample_weight;
      now_r    <= in_now_ms;
    end
  end

  // noise clamp: negative or below the floor reads as zero
  function automatic logic [W-2:0] clamp_f(input logic signed [W-1:0] v,
                                           input logic [NOISE_W-1:0] nf);
    logic [W-2:0] mag;
    mag = v[W-2:0];
    if (v[W-1] || (CW'(mag) < CW'(nf))) begin
      return '0;
    end
    return mag;
  endfunction

  // state
  logic signed [W-1:0] smoothed_r, smoothed_nxt;
  logic                primed_r, primed_nxt;
  logic [W-2:0]        confirmed_r, confirmed_nxt;
  logic signed [W-1:0] win_low_r, win_low_nxt;
  logic signed [W-1:0] win_high_r, win_high_nxt;
  logic [TIME_W-1:0]   win_start_r, win_start_nxt;

  logic                out_changed_nxt;
  logic                out_added_nxt;
  logic signed [W-1:0] out_change_nxt;

  logic signed [W:0]   sm_diff;
  logic signed [W:0]   sm_step;
  logic signed [W:0]   sm_sum;
  logic signed [W-1:0] sm_new;
  logic signed [W-1:0] low_base, high_base;
  logic [TIME_W-1:0]   start_base;
  logic [W-2:0]        cur;
  logic signed [W-1:0] cur_s;
  logic signed [W-1:0] low1, high1;
  logic [TIME_W-1:0]   elapsed;
  logic signed [W:0]   spread;
  logic                band_ok;
  logic signed [W:0]   mid_sum;
  logic signed [W:0]   mid_half;
  logic [W-2:0]        mid_c;
  logic signed [W-1:0] delta;
  logic [W-1:0]        delta_abs;
  logic                hit;

  always_comb begin
    sm_diff = {sample_r[W-1], sample_r} - {smoothed_r[W-1], smoothed_r};
    sm_step = sm_diff >>> smoothing_shift_r;
    sm_sum  = {smoothed_r[W-1], smoothed_r} + sm_step;

    if (!primed_r) begin
      sm_new     = sample_r;
      low_base   = sample_r;
      high_base  = sample_r;
      start_base = now_r;
    end else begin
      sm_new     = sm_sum[W-1:0];
      low_base   = win_low_r;
      high_base  = win_high_r;
      start_base = win_start_r;
    end

    cur   = clamp_f(sm_new, noise_floor_r);
    cur_s = {1'b0, cur};
    low1  = (cur_s < low_base) ? cur_s : low_base;
    high1 = (cur_s > high_base) ? cur_s : high_base;

    elapsed  = now_r - start_base;
    spread   = {high1[W-1], high1} - {low1[W-1], low1};
    band_ok  = !spread[W] && (CW'(spread[W-1:0]) <= CW'(stable_band_r));
    mid_sum  = {low1[W-1], low1} + {high1[W-1], high1};
    mid_half = mid_sum >>> 1;
    mid_c    = clamp_f(mid_half[W-1:0], noise_floor_r);
    delta    = {1'b0, mid_c} - {1'b0, confirmed_r};
    delta_abs = delta[W-1] ? W'(-delta) : W'(delta);
    hit      = band_ok && (CW'(delta_abs) > CW'(item_threshold_r));

    smoothed_nxt    = sm_new;
    primed_nxt      = 1'b1;
    confirmed_nxt   = confirmed_r;
    win_low_nxt     = low1;
    win_high_nxt    = high1;
    win_start_nxt   = start_base;
    out_changed_nxt = 1'b0;
    out_added_nxt   = 1'b0;
    out_change_nxt  = '0;

    if (elapsed >= TIME_W'(window_ms_r)) begin
      if (hit) begin
        confirmed_nxt   = mid_c;
        out_changed_nxt = 1'b1;
        out_added_nxt   = !delta[W-1];
        out_change_nxt  = delta;
      end
      win_low_nxt   = cur_s;
      win_high_nxt  = cur_s;
      win_start_nxt = now_r;
    end

    if (cmd_r == CMD_CLEAR) begin
      smoothed_nxt    = '0;
      primed_nxt      = 1'b0;
      confirmed_nxt   = '0;
      win_low_nxt     = '0;
      win_high_nxt    = '0;
      win_start_nxt   = now_r;
      out_changed_nxt = 1'b0;
      out_added_nxt   = 1'b0;
      out_change_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothed_r  <= '0;
      primed_r    <= 1'b0;
      confirmed_r <= '0;
      win_low_r   <= '0;
      win_high_r  <= '0;
      win_start_r <= '0;
    end else if (advance) begin
      smoothed_r  <= smoothed_nxt;
      primed_r    <= primed_nxt;
      confirmed_r <= confirmed_nxt;
      win_low_r   <= win_low_nxt;
      win_high_r  <= win_high_nxt;
      win_start_r <= win_start_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_changed       <= out_changed_nxt;
      out_added         <= out_added_nxt;
      out_new_weight    <= confirmed_nxt;
      out_weight_change <= out_change_nxt;
    end
  end

  `LCCD_ASSERT_NOW(a_chg_nonzero, clk, rst_n, out_valid && out_changed, out_weight_change != '0)
  `LCCD_ASSERT_NOW(a_nochg_zero, clk, rst_n, out_valid && !out_changed, out_weight_change == '0 && !out_added)
  `LCCD_ASSERT_NOW(a_added_sign, clk, rst_n, out_valid && out_added, !out_weight_change[W-1])
  `LCCD_ASSERT_NEXT(a_clear, clk, rst_n, advance && cmd_r == CMD_CLEAR, !primed_r && confirmed_r == '0 && out_new_weight == '0)
  `LCCD_ASSERT_NEXT(a_in_hold, clk, rst_n, in_vld_r && !advance, in_vld_r && $stable(sample_r) && $stable(now_r))

endmodule

/* tb/load_cell_change_detector_unit_tb.sv */
`timescale 1ns / 100ps

module load_cell_change_detector_unit_tb;
  import lccd_pkg::*;

  localparam int WB = WEIGHT_BITS_DEF;
  localparam int CLK_PERIOD = 12;
  localparam int TIMEOUT_CYCLES = 400_000;
  localparam int LONG_STALL_CYCLES = 400;
  localparam int END_SETTLE_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(REG_SMOOTHING_SHIFT + 1);
  localparam longint W_MAX = (longint'(1) << (WB - 1)) - 1;
  localparam longint W_MIN = -(longint'(1) << (WB - 1));

  typedef struct {
    cmd_t                 cmd;
    logic signed [WB-1:0] weight;
    logic [TIME_W-1:0]    now;
    bit                   hold;
  } sample_word_t;

  typedef struct {
    logic                 changed;
    logic                 added;
    logic [WB-2:0]        new_weight;
    logic signed [WB-1:0] weight_change;
  } report_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_cmd = 1'b0;
  logic signed [WB-1:0]  in_sample_weight = '0;
  logic [TIME_W-1:0]     in_now_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_changed;
  logic                  out_added;
  logic [WB-2:0]         out_new_weight;
  logic signed [WB-1:0]  out_weight_change;

  load_cell_change_detector_unit #(
    .WEIGHT_BITS(WB)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_sample_weight (in_sample_weight),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_changed      (out_changed),
    .out_added        (out_added),
    .out_new_weight   (out_new_weight),
    .out_weight_change(out_weight_change)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // register mirror
  logic [NOISE_W-1:0]  floor_q = NOISE_FLOOR_RST;
  logic [THRESH_W-1:0] thr_q   = ITEM_THRESHOLD_RST;
  logic [BAND_W-1:0]   band_q  = STABLE_BAND_RST;
  logic [WIN_W-1:0]    win_q   = WINDOW_MS_RST;
  logic [SHIFT_W-1:0]  shift_q = SMOOTHING_SHIFT_RST;

  // detector state mirror
  logic signed [WB-1:0] smooth_q = '0;
  logic signed [WB-1:0] basket_q = '0;
  logic signed [WB-1:0] win_lo_q = '0;
  logic signed [WB-1:0] win_hi_q = '0;
  bit                   primed_q = 1'b0;
  logic [TIME_W-1:0]    win_t0_q = '0;

  sample_word_t sample_backlog[$];
  report_t      expected_reports[$];
  sample_word_t on_wire;
  int           sent_cnt = 0;
  int           got_cnt = 0;
  int           fail_cnt = 0;
  bit           long_stall = 1'b0;
  int           tx_burst = 1;
  int           tx_gap = 0;
  rx_mode_t     rx_mode = RX_OPEN;
  int           rx_left = 0;
  logic [TIME_W-1:0] stim_clock = 32'd5000;
  longint       stim_level = 0;

  function automatic longint clamp_noise(longint v);
    if (v < 0 || v < longint'(floor_q)) return 0;
    return v;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_NOISE_FLOOR:     floor_q = data[NOISE_W-1:0];
      REG_ITEM_THRESHOLD:  thr_q   = data[THRESH_W-1:0];
      REG_STABLE_BAND:     band_q  = data[BAND_W-1:0];
      REG_WINDOW_MS:       win_q   = data[WIN_W-1:0];
      REG_SMOOTHING_SHIFT: shift_q = data[SHIFT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic report_t track_basket(sample_word_t s);
    report_t           r;
    longint            cur;
    longint            mid;
    longint            d;
    logic [TIME_W-1:0] elapsed;
    r.changed = 1'b0;
    r.added = 1'b0;
    r.weight_change = '0;
    if (s.cmd == CMD_CLEAR) begin
      smooth_q = '0;
      primed_q = 1'b0;
      basket_q = '0;
      win_lo_q = '0;
      win_hi_q = '0;
      win_t0_q = s.now;
    end else begin
      if (!primed_q) begin
        smooth_q = s.weight;
        primed_q = 1'b1;
        win_lo_q = s.weight;
        win_hi_q = s.weight;
        win_t0_q = s.now;
      end else begin
        smooth_q = WB'(longint'(smooth_q) +
                       ((longint'(s.weight) - longint'(smooth_q)) >>> shift_q));
      end
      cur = clamp_noise(longint'(smooth_q));
      if (cur < longint'(win_lo_q)) win_lo_q = WB'(cur);
      if (cur > longint'(win_hi_q)) win_hi_q = WB'(cur);
      elapsed = s.now - win_t0_q;
      if (elapsed >= {16'b0, win_q}) begin
        if (longint'(win_hi_q) - longint'(win_lo_q) <= longint'(band_q)) begin
          mid = clamp_noise((longint'(win_lo_q) + longint'(win_hi_q)) >>> 1);
          d = mid - longint'(basket_q);
          if ((d < 0 ? -d : d) > longint'(thr_q)) begin
            basket_q = WB'(mid);
            r.changed = 1'b1;
            r.added = (d > 0);
            r.weight_change = WB'(d);
          end
        end
        win_lo_q = WB'(cur);
        win_hi_q = WB'(cur);
        win_t0_q = s.now;
      end
    end
    r.new_weight = basket_q[WB-2:0];
    return r;
  endfunction

  function automatic void push_word(cmd_t c, longint w, logic [TIME_W-1:0] t, bit hold);
    sample_word_t s;
    s.cmd = c;
    s.weight = WB'(w);
    s.now = t;
    s.hold = hold;
    sample_backlog.push_back(s);
  endfunction

  // mostly settled levels with small jitter and item-sized steps, plus clears and junk words
  function automatic void queue_scene(int n);
    int     k;
    int     kind;
    int     settle;
    bit     hold;
    longint w;
    longint amp;
    longint jump;
    settle = 0;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0)
        stim_clock = stim_clock + $urandom_range(win_q, 2 * win_q + 3);
      else
        stim_clock = stim_clock + $urandom_range(0, win_q / 3 + 2);
      if (settle <= 0) begin
        settle = $urandom_range(4, 30 + (1 << shift_q) / 2);
        jump = longint'(thr_q) + 1 + $urandom_range(0, thr_q / 2 + 64);
        case ($urandom_range(0, 5))
          0: stim_level = 0;
          1: stim_level = -longint'($urandom_range(0, floor_q + 10));
          default: begin
            if (stim_level + jump > W_MAX ||
                (stim_level - jump >= 0 && $urandom_range(0, 1) != 0))
              stim_level = stim_level - jump;
            else
              stim_level = stim_level + jump;
          end
        endcase
      end
      settle--;
      amp = $urandom_range(0, band_q / 6 + 2);
      w = stim_level - amp + longint'($urandom_range(0, 32'(2 * amp)));
      if (w > W_MAX) w = W_MAX;
      if (w < W_MIN) w = W_MIN;
      hold = (k == n / 2) || ($urandom_range(0, 149) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 3)
        push_word(CMD_CLEAR, $signed(WB'($urandom)), stim_clock, hold);
      else if (kind < 9)
        push_word(CMD_SAMPLE, $signed(WB'($urandom)),
                  ($urandom_range(0, 1) != 0) ? $urandom : stim_clock, hold);
      else
        push_word(CMD_SAMPLE, w, stim_clock, hold);
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (sample_backlog.size() != 0 || in_valid || got_cnt < sent_cnt);
  endtask

  function automatic void check_field(string name, logic [WB-1:0] want, logic [WB-1:0] seen,
                                      bit as_signed);
    if (seen !== want) begin
      if (as_signed)
        $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(seen));
      else
        $error("%s: expected %0d, actual %0d", name, want, seen);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin : drive_samples
    bit           accepted;
    bit           next_valid;
    sample_word_t w;
    accepted = in_valid && in_ready;
    next_valid = in_valid && !accepted;
    if (rst_n) begin
      if (accepted) begin
        expected_reports.push_back(track_basket(on_wire));
        sent_cnt <= sent_cnt + 1;
      end
      if (!next_valid) begin
        if (tx_gap > 0) begin
          tx_gap = tx_gap - 1;
        end else if (sample_backlog.size() != 0 &&
                     !(sample_backlog[0].hold && (accepted || got_cnt < sent_cnt))) begin
          w = sample_backlog.pop_front();
          on_wire = w;
          in_cmd <= w.cmd;
          in_sample_weight <= w.weight;
          in_now_ms <= w.now;
          next_valid = 1'b1;
          tx_burst = tx_burst - 1;
          if (tx_burst <= 0) begin
            tx_burst = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
            tx_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
    in_valid <= next_valid;
  end

  always @(posedge clk) begin : watch_reports
    report_t want;
    bit      rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_cnt <= got_cnt + 1;
        if (expected_reports.size() == 0) begin
          $error("result word with no expectation waiting");
          fail_cnt++;
        end else begin
          want = expected_reports.pop_front();
          check_field("changed", WB'(want.changed), WB'(out_changed), 1'b0);
          check_field("added", WB'(want.added), WB'(out_added), 1'b0);
          check_field("new_weight", WB'(want.new_weight), WB'(out_new_weight), 1'b0);
          check_field("weight_change", want.weight_change, out_weight_change, 1'b1);
        end
      end
      if (rx_left <= 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(4, 90);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:   rdy = 1'b1;
        RX_COIN:   rdy = $urandom_range(0, 1);
        RX_SPARSE: rdy = ($urandom_range(0, 4) == 0);
        default:   rdy = ~out_ready;
      endcase
      out_ready <= rdy && !long_stall;
    end
  end

  // output side blocked long enough for the pipeline to back up into the input
  initial begin : receiver_hold_off
    while (got_cnt < 120) @(negedge clk);
    long_stall = 1'b1;
    repeat (LONG_STALL_CYCLES) @(negedge clk);
    long_stall = 1'b0;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Mismatches found");
    $finish;
  end

  initial begin : run_phases
    int k;
    int p;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values
    push_word(CMD_CLEAR, 0, 32'd100, 1'b0);
    push_word(CMD_SAMPLE, W_MIN, 32'd100, 1'b0);
    push_word(CMD_SAMPLE, W_MAX, 32'd150, 1'b0);
    push_word(CMD_SAMPLE, W_MAX, 32'd900, 1'b0);
    for (k = 0; k < 6; k++) push_word(CMD_SAMPLE, 16000, 32'(1000 + 300 * k), 1'b0);
    for (k = 0; k < 5; k++) push_word(CMD_SAMPLE, 0, 32'(2800 + 300 * k), 1'b0);
    push_word(CMD_CLEAR, W_MAX, 32'hFFFF_FE00, 1'b0);
    for (k = 0; k < 6; k++) push_word(CMD_SAMPLE, 4000, 32'hFFFF_FE00 + 32'(250 * k), 1'b0);
    push_word(CMD_CLEAR, -1, 32'hFFFF_FFFF, 1'b0);
    push_word(CMD_SAMPLE, 800, 32'd0, 1'b0);
    wait_drained();

    write_reg(REG_NOISE_FLOOR, 20'd80);
    write_reg(REG_ITEM_THRESHOLD, 20'd800);
    write_reg(REG_STABLE_BAND, 20'd240);
    write_reg(REG_WINDOW_MS, 20'd100);
    write_reg(REG_SMOOTHING_SHIFT, 20'd2);
    queue_scene(300);
    wait_drained();

    // all zero; high data bits above narrow registers must be dropped
    write_reg(REG_NOISE_FLOOR, 20'hA0000);
    write_reg(REG_ITEM_THRESHOLD, 20'd0);
    write_reg(REG_STABLE_BAND, 20'd0);
    write_reg(REG_WINDOW_MS, 20'h30000);
    write_reg(REG_SMOOTHING_SHIFT, 20'hFFFF8);
    queue_scene(200);
    wait_drained();

    for (k = REG_NOISE_FLOOR; k <= REG_SMOOTHING_SHIFT; k++) write_reg(CFG_IDX_W'(k), '1);
    stim_clock = 32'hFFF0_0000;
    queue_scene(200);
    wait_drained();

    for (p = 0; p < 3; p++) begin
      write_reg(REG_NOISE_FLOOR, {4'($urandom), 16'($urandom_range(0, 400))});
      write_reg(REG_ITEM_THRESHOLD, 20'($urandom_range(0, 6000)));
      write_reg(REG_STABLE_BAND, 20'($urandom_range(0, 2500)));
      write_reg(REG_WINDOW_MS, {4'($urandom), 16'($urandom_range(0, 3000))});
      write_reg(REG_SMOOTHING_SHIFT, {17'($urandom), 3'($urandom_range(0, 7))});
      for (k = REG_SPARE_FIRST; k < 2 ** CFG_IDX_W; k++) write_reg(CFG_IDX_W'(k), 20'($urandom));
      queue_scene((p == 1) ? 250 : 300);
      wait_drained();
    end

    repeat (END_SETTLE_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $error("%0d expected result words never arrived", expected_reports.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/lccd_pkg.sv
rtl/core/load_cell_change_detector_unit.sv
tb/load_cell_change_detector_unit_tb.sv
